@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dsfpc_pkg.sv @@
`default_nettype none

package dsfpc_pkg;

  // Error codes carried in sensor_error.
  localparam logic [1:0] ERR_NORMAL    = 2'd0;
  localparam logic [1:0] ERR_SENSOR1   = 2'd1;
  localparam logic [1:0] ERR_SENSOR2   = 2'd2;
  localparam logic [1:0] ERR_INTERFERE = 2'd3;

  // Lost limit after reset, and saturation value of the lost counts.
  localparam logic [7:0] LIMIT_RESET = 8'd10;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // Interference pin pattern that signals a magnetic disturbance.
  localparam logic [1:0] PINS_INTERFERE = 2'b00;

  // Sensor selection codes.
  localparam logic REQ_SENSOR1 = 1'b0;

  // One sensor edge event.
  typedef struct packed {
    logic       req_type;
    logic       pin_level;
    logic [1:0] interfere_pins;
    logic       report_busy;
  } event_t;

  // One result item.
  typedef struct packed {
    logic [31:0] forward_flow;
    logic [1:0]  sensor_error;
    logic        alarm_request;
    logic        sensor1_fault_mark;
    logic        sensor2_fault_mark;
    logic        interfere_mark;
  } result_t;

  // Saturating increment of a lost count.
  function automatic logic [7:0] bump(input logic [7:0] c);
    logic [7:0] r;
    r = (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dsfpc_core.sv @@
`default_nettype none

module dsfpc_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire dsfpc_pkg::event_t  item,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  output dsfpc_pkg::result_t      result
);

  logic [7:0]  lost_limit;
  logic        direction_armed, direction_armed_next;
  logic [31:0] flow_count, flow_count_next;
  logic [7:0]  lost_count_one, lost_count_one_next;
  logic [7:0]  lost_count_two, lost_count_two_next;
  logic [1:0]  error_code, error_code_next;
  logic        mark_one, mark_one_next;
  logic        mark_two, mark_two_next;
  logic        mark_interfere, mark_interfere_next;
  logic        alarm;

  // Next state for one event; a pin that reads high leaves everything alone.
  always_comb begin
    direction_armed_next = direction_armed;
    flow_count_next      = flow_count;
    lost_count_one_next  = lost_count_one;
    lost_count_two_next  = lost_count_two;
    error_code_next      = error_code;
    mark_one_next        = mark_one;
    mark_two_next        = mark_two;
    mark_interfere_next  = mark_interfere;
    alarm                = 1'b0;
    if (!item.pin_level) begin
      if (item.req_type == dsfpc_pkg::REQ_SENSOR1) begin
        direction_armed_next = 1'b1;
        lost_count_one_next  = 8'd0;
        if (error_code == dsfpc_pkg::ERR_SENSOR1) begin
          error_code_next = dsfpc_pkg::ERR_NORMAL;
        end
        lost_count_two_next = dsfpc_pkg::bump(lost_count_two);
        if (lost_count_two_next > lost_limit) begin
          error_code_next = dsfpc_pkg::ERR_SENSOR2;
          if (!mark_two) begin
            mark_two_next = 1'b1;
            alarm         = 1'b1;
          end
        end
      end else begin
        if (direction_armed) begin
          flow_count_next = flow_count + 32'd1;
        end
        direction_armed_next = 1'b0;
        lost_count_two_next  = 8'd0;
        if (error_code == dsfpc_pkg::ERR_SENSOR2) begin
          error_code_next = dsfpc_pkg::ERR_NORMAL;
        end
        lost_count_one_next = dsfpc_pkg::bump(lost_count_one);
        if (lost_count_one_next > lost_limit) begin
          error_code_next = dsfpc_pkg::ERR_SENSOR1;
          if (!mark_one) begin
            mark_one_next = 1'b1;
            alarm         = 1'b1;
          end
        end
      end
      // The interference check runs last and overrides any sensor code.
      if (item.interfere_pins == dsfpc_pkg::PINS_INTERFERE) begin
        error_code_next = dsfpc_pkg::ERR_INTERFERE;
        if (!mark_interfere) begin
          mark_interfere_next = 1'b1;
          alarm               = 1'b1;
        end
      end else if (error_code_next == dsfpc_pkg::ERR_INTERFERE) begin
        error_code_next = dsfpc_pkg::ERR_NORMAL;
      end
    end
  end

  // Result reflects the state after the event.
  always_comb begin
    result.forward_flow       = flow_count_next;
    result.sensor_error       = error_code_next;
    result.alarm_request      = alarm & ~item.report_busy;
    result.sensor1_fault_mark = mark_one_next;
    result.sensor2_fault_mark = mark_two_next;
    result.interfere_mark     = mark_interfere_next;
  end

  // State registers, updated only when an event is processed; lost_limit follows cfg_wr_en.
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_limit      <= dsfpc_pkg::LIMIT_RESET;
      direction_armed <= 1'b0;
      flow_count      <= 32'd0;
      lost_count_one  <= 8'd0;
      lost_count_two  <= 8'd0;
      error_code      <= dsfpc_pkg::ERR_NORMAL;
      mark_one        <= 1'b0;
      mark_two        <= 1'b0;
      mark_interfere  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lost_limit <= cfg_wr_data;
      end
      if (fire) begin
        direction_armed <= direction_armed_next;
        flow_count      <= flow_count_next;
        lost_count_one  <= lost_count_one_next;
        lost_count_two  <= lost_count_two_next;
        error_code      <= error_code_next;
        mark_one        <= mark_one_next;
        mark_two        <= mark_two_next;
        mark_interfere  <= mark_interfere_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dual_sensor_flow_pulse_counter.sv @@
// Hall-sensor flow meter pulse counter.
// Input channel (in_valid, in_stall, in_item) carries one falling-edge event
// from either sensor; output channel (out_valid, out_stall, out_item) returns
// one result per event: flow count, error code, alarm request and the marks.
// A transfer takes place on a clock edge with valid high and stall low.
// The lost limit is to be written through cfg_wr_en and cfg_wr_data only while idle; the block does not enforce this.
// Events pass an input register and then the state update, whose result is
// captured in the output register. One event is taken every cycle unless
// the receiver stalls; the state update is a single short step of
// combinational logic.
// Synchronous reset clears the counts, error code, marks and direction flag,
// sets the lost limit to ten and empties both registers.
// When the receiver stalls, the result holds; the input register still takes
// one more event, and in_stall rises only once both registers are full.
`default_nettype none

module dual_sensor_flow_pulse_counter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dsfpc_pkg::event_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dsfpc_pkg::result_t      out_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data
);

  `include "assert_macros.svh"

  logic               held_valid;
  dsfpc_pkg::event_t  held;
  logic               advance;
  logic               fire;
  dsfpc_pkg::result_t result_next;

  // The pipeline moves when the output register is empty or being drained.
  assign advance  = ~out_valid | ~out_stall;
  assign fire     = held_valid & advance;
  assign in_stall = held_valid & ~advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (~held_valid | advance) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((~held_valid | advance) && in_valid) begin
      held <= in_item;
    end
  end

  dsfpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (held),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .result      (result_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result_next;
    end
  end

  // An alarm is only requested together with a freshly set mark.
  `ASSERT_IMPLIES(a_alarm_has_mark, clk, rst, out_valid && out_item.alarm_request,
    out_item.sensor1_fault_mark || out_item.sensor2_fault_mark || out_item.interfere_mark,
    "alarm request without any fault mark")
  // Interference code is never shown without its mark.
  `ASSERT_IMPLIES(a_interfere_mark, clk, rst,
    out_valid && (out_item.sensor_error == dsfpc_pkg::ERR_INTERFERE),
    out_item.interfere_mark, "interference code without mark")
  // The input side stalls only while a result is held back.
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, in_stall,
    out_valid && out_stall && held_valid, "input stalled with room downstream")
  // A stalled result register still holds a result in the next cycle.
  `ASSERT_NEXT(a_result_kept, clk, rst, out_valid && out_stall, out_valid,
    "result dropped while stalled")

endmodule

`default_nettype wire

@@ verif/flow_check_pkg.sv @@
package flow_check_pkg;

  import dsfpc_pkg::*;

  // Tracks the meter state, predicts one result per sensor event and checks
  // the results that leave the block against those predictions, in order.
  class pulse_count_tracker;

    logic [7:0]  lost_limit;
    logic        armed;
    logic [31:0] flow;
    logic [7:0]  lost_one;
    logic [7:0]  lost_two;
    logic [1:0]  code;
    logic        mark_one;
    logic        mark_two;
    logic        mark_intf;
    result_t     expected_results[$];
    int unsigned mismatches;

    function new();
      lost_limit = LIMIT_RESET;
      armed      = 1'b0;
      flow       = '0;
      lost_one   = '0;
      lost_two   = '0;
      code       = ERR_NORMAL;
      mark_one   = 1'b0;
      mark_two   = 1'b0;
      mark_intf  = 1'b0;
      mismatches = 0;
    endfunction

    // A lost count stops at its maximum rather than wrapping.
    function logic [7:0] sat_inc(input logic [7:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + 8'd1;
    endfunction

    // Applies one accepted sensor event and queues the result it should give.
    function void take_event(input event_t ev);
      result_t r;
      logic    raised;
      raised = 1'b0;
      r      = '0;
      if (ev.pin_level == 1'b0) begin
        if (ev.req_type == REQ_SENSOR1) begin
          armed    = 1'b1;
          lost_one = '0;
          if (code == ERR_SENSOR1) code = ERR_NORMAL;
          lost_two = sat_inc(lost_two);
          if (lost_two > lost_limit) begin
            code = ERR_SENSOR2;
            if (!mark_two) begin
              mark_two = 1'b1;
              raised   = 1'b1;
            end
          end
        end else begin
          if (armed) flow = flow + 32'd1;
          armed    = 1'b0;
          lost_two = '0;
          if (code == ERR_SENSOR2) code = ERR_NORMAL;
          lost_one = sat_inc(lost_one);
          if (lost_one > lost_limit) begin
            code = ERR_SENSOR1;
            if (!mark_one) begin
              mark_one = 1'b1;
              raised   = 1'b1;
            end
          end
        end
        // The interference check comes last and overrides a sensor fault code.
        if (ev.interfere_pins == PINS_INTERFERE) begin
          code = ERR_INTERFERE;
          if (!mark_intf) begin
            mark_intf = 1'b1;
            raised    = 1'b1;
          end
        end else if (code == ERR_INTERFERE) begin
          code = ERR_NORMAL;
        end
        r.alarm_request = raised && !ev.report_busy;
      end
      r.forward_flow       = flow;
      r.sensor_error       = code;
      r.sensor1_fault_mark = mark_one;
      r.sensor2_fault_mark = mark_two;
      r.interfere_mark     = mark_intf;
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(input result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: flow=%0d err=%0d alarm=%0b marks=%0b%0b%0b",
                   got.forward_flow, got.sensor_error, got.alarm_request,
                   got.sensor1_fault_mark, got.sensor2_fault_mark, got.interfere_mark);
        return;
      end
      want = expected_results.pop_front();
      if (got.forward_flow !== want.forward_flow ||
          got.sensor_error !== want.sensor_error ||
          got.alarm_request !== want.alarm_request ||
          got.sensor1_fault_mark !== want.sensor1_fault_mark ||
          got.sensor2_fault_mark !== want.sensor2_fault_mark ||
          got.interfere_mark !== want.interfere_mark) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result mismatch: expected flow=%0d err=%0d alarm=%0b marks=%0b%0b%0b,",
                   want.forward_flow, want.sensor_error, want.alarm_request,
                   want.sensor1_fault_mark, want.sensor2_fault_mark, want.interfere_mark);
          $display("  got flow=%0d err=%0d alarm=%0b marks=%0b%0b%0b",
                   got.forward_flow, got.sensor_error, got.alarm_request,
                   got.sensor1_fault_mark, got.sensor2_fault_mark, got.interfere_mark);
        end
      end
    endfunction

  endclass

endpackage

@@ verif/tb_dual_sensor_flow_pulse_counter.sv @@
module tb_dual_sensor_flow_pulse_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import dsfpc_pkg::*;
  import flow_check_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PER_PHASE   = 240;

  logic    clk         = 1'b0;
  logic    rst         = 1'b1;
  logic    in_valid    = 1'b0;
  logic    in_stall;
  event_t  in_item     = '0;
  logic    out_valid;
  logic    out_stall   = 1'b0;
  result_t out_item;
  logic    cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  pulse_count_tracker model = new();

  int  cycles     = 0;
  int  fed        = 0;
  int  gap_odds   = 0;
  int  stall_odds = 0;
  int  stall_left = 0;
  bit  quiet      = 1'b0;

  dual_sensor_flow_pulse_counter u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5ns clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls in bursts of random length.
  always @(posedge clk) begin
    if (rst || quiet || stall_left == 0) begin
      out_stall <= 1'b0;
      if (!rst && !quiet && $urandom_range(0, 99) < stall_odds)
        stall_left <= $urandom_range(1, 19);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) model.check_result(out_item);
  end

  function automatic event_t make_event(input logic req, input logic lvl,
                                        input logic [1:0] pins, input logic busy);
    event_t ev;
    ev.req_type       = req;
    ev.pin_level      = lvl;
    ev.interfere_pins = pins;
    ev.report_busy    = busy;
    return ev;
  endfunction

  // Mostly processed edges, with some high pins, interference and busy uplink.
  function automatic event_t random_event(input logic req);
    logic [1:0] pins;
    pins = ($urandom_range(0, 5) == 0) ? PINS_INTERFERE : 2'($urandom_range(0, 3));
    return make_event(req, ($urandom_range(0, 9) == 0), pins, ($urandom_range(0, 2) == 0));
  endfunction

  // Holds the event on the input until its transfer, then notes it.
  task automatic send_event(input event_t ev);
    in_item  <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.take_event(ev);
  endtask

  task automatic hold_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one event, counts it if the block acts on it, and sometimes pauses.
  task automatic emit(input event_t ev);
    send_event(ev);
    if (ev.pin_level == 1'b0) fed++;
    if (!quiet && $urandom_range(0, 99) < gap_odds) hold_input($urandom_range(1, 19));
  endtask

  // Stops sending until every predicted result has been checked.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model.lost_limit = v;
  endtask

  initial begin
    int   phase_limit[6];
    int   gap_by_phase[6];
    int   stall_by_phase[6];
    int   lim;
    int   pick;
    int   len;
    logic req;
    phase_limit    = '{0, 254, 1, -1, 10, -1};
    gap_by_phase   = '{6, 0, 25, 10, 3, 0};
    stall_by_phase = '{8, 3, 0, 20, 5, 0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset limit of ten.
    gap_odds   = 15;
    stall_odds = 10;
    emit(make_event(1'b1, 1'b0, 2'd3, 1'b0));     // edge from sensor two while disarmed
    emit(make_event(1'b0, 1'b1, 2'd3, 1'b0));     // high pin is ignored
    emit(make_event(1'b0, 1'b0, 2'd2, 1'b0));     // arm
    emit(make_event(1'b1, 1'b0, 2'd1, 1'b0));     // one unit of forward flow
    emit(make_event(1'b0, 1'b0, PINS_INTERFERE, 1'b1)); // first interference, uplink busy
    emit(make_event(1'b0, 1'b0, PINS_INTERFERE, 1'b0)); // already marked, no alarm
    emit(make_event(1'b1, 1'b0, 2'd3, 1'b1));     // interference clears
    emit(make_event(1'b1, 1'b1, PINS_INTERFERE, 1'b1)); // ignored despite the pins
    // Eleven sensor one edges in a row push sensor two past the limit.
    for (int i = 0; i < 11; i++)
      emit(make_event(1'b0, 1'b0, 2'd3, i[0]));
    emit(make_event(1'b1, 1'b0, 2'd3, 1'b0));     // sensor two fault clears
    emit(make_event(1'b1, 1'b0, PINS_INTERFERE, 1'b0)); // interference overrides
    emit(make_event(1'b0, 1'b0, 2'd3, 1'b1));     // and clears again

    // Random phases, each under its own limit.
    for (int p = 0; p < 6; p++) begin
      wait_for_results();
      lim = (phase_limit[p] < 0) ? $urandom_range(2, 253) : phase_limit[p];
      write_limit(8'(lim));
      gap_odds   = gap_by_phase[p];
      stall_odds = stall_by_phase[p];
      quiet      = (p == 5);
      fed        = 0;
      // Under the highest limit, long runs from each sensor drive the lost counts up toward saturation.
      if (lim == 254) begin
        for (int i = 0; i < 260; i++) emit(random_event(1'b0));
        for (int i = 0; i < 260; i++) emit(random_event(1'b1));
      end
      while (fed < PER_PHASE) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          req = 1'($urandom_range(0, 1));
          len = $urandom_range(1, lim + 6);
          for (int i = 0; i < len; i++) emit(random_event(req));
        end else if (pick <= 2) begin
          emit(random_event(1'($urandom_range(0, 1))));
        end else if (pick == 3 && !quiet && $urandom_range(0, 3) == 0) begin
          wait_for_results();
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            emit(random_event(REQ_SENSOR1));
            emit(random_event(~REQ_SENSOR1));
          end
        end
      end
    end

    wait_for_results();
    repeat (6) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dsfpc_pkg.sv
hw/rtl/dsfpc_core.sv
hw/rtl/dual_sensor_flow_pulse_counter.sv
verif/flow_check_pkg.sv
verif/tb_dual_sensor_flow_pulse_counter.sv
